@@ hdl/bba_pkg.sv @@
// Shared constants and types of the bitmap bit allocator.
`timescale 1ns / 1ps
package bba_pkg;

	// Default geometry of the mark store.
	localparam int WORD_BITS_DEF  = 32;
	localparam int TOTAL_BITS_DEF = 1024;

	// The allocated index is 10 bits wide, so no count above this is usable.
	localparam int INDEX_SPAN = 1024;

	localparam int REQ_W = 3;
	localparam int IDX_W = 10;
	localparam int CNT_W = 11;

	localparam logic [CNT_W-1:0] BIT_COUNT_RESET = 11'd1024;

	// Configuration port.
	localparam int APB_AW = 2;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-1:0] ADDR_BIT_COUNT = 2'd0;

	typedef enum logic [REQ_W-1:0] {
		REQ_SET       = 3'd0,
		REQ_CLEAR     = 3'd1,
		REQ_TEST      = 3'd2,
		REQ_SET_ALL   = 3'd3,
		REQ_CLEAR_ALL = 3'd4,
		REQ_FIND      = 3'd5
	} req_code_t;

endpackage

@@ hdl/bba_chan_if.sv @@
// Valid/ready channel interfaces for requests and responses of the allocator.
`timescale 1ns / 1ps
interface bba_req_if;
	logic                        valid;
	logic                        ready;
	logic [bba_pkg::REQ_W-1:0]   req_type;
	logic [bba_pkg::IDX_W-1:0]   bit_index;

	modport source (output valid, output req_type, output bit_index, input ready);
	modport sink   (input valid, input req_type, input bit_index, output ready);
endinterface

interface bba_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        bit_was_set;
	logic [bba_pkg::IDX_W-1:0]   alloc_index;
	logic                        failed;

	modport source (output valid, output bit_was_set, output alloc_index, output failed,
		input ready);
	modport sink   (input valid, input bit_was_set, input alloc_index, input failed,
		output ready);
endinterface

@@ hdl/bba_mark_store.sv @@
// Word store of allocation marks with per-word valid bits and a registered read.
`timescale 1ns / 1ps
module bba_mark_store #(
	parameter int WORD_BITS = bba_pkg::WORD_BITS_DEF,
	parameter int DEPTH     = 32,
	parameter int AW        = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic [WORD_BITS-1:0] wr_data,
	input  logic [AW-1:0]        rd_addr,
	output logic [WORD_BITS-1:0] rd_data
);

	logic [WORD_BITS-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]     vld_q;
	logic [WORD_BITS-1:0] rd_word_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_word_q <= mem_q[rd_addr];
	end

	// A word never written reads as zero, which is its reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_word_q : '0;

endmodule

@@ hdl/bitmap_bit_allocator.sv @@
// Top level of the bitmap bit allocator: sequencer, shared word adder and APB register.
`timescale 1ns / 1ps
//
//  Channel   Role    Handshake           Content
//  req       sink    valid/ready         req_type, bit_index
//  rsp       source  valid/ready         bit_was_set, alloc_index, failed
//  apb       slave   psel/penable        bit_count at byte address 0
//
// Find and set scans one word a cycle through the registered store read until a free bit
// turns up or the words that cover the count are passed; set all and clear all write each
// covering word in turn; set, clear and test step to their word with the shared adder.
// Failing set, clear and test requests and unknown codes go straight to the final state.
// Reset clears the store's valid bits, so no clearing pass runs.
// A stalled rsp holds the sequencer in its final state, and req is ready only when idle.
module bitmap_bit_allocator #(
	parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF,
	parameter int TOTAL_BITS = bba_pkg::TOTAL_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bba_pkg::APB_AW-1:0]   paddr,
	input  logic [bba_pkg::APB_DW-1:0]   pwdata,
	output logic [bba_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	bba_req_if.sink                      req,
	bba_rsp_if.source                    rsp
);

	// Only bits below the index span can ever be touched, so the store holds just the
	// words that cover them.
	localparam int LIMIT      = (TOTAL_BITS < bba_pkg::INDEX_SPAN) ? TOTAL_BITS
		: bba_pkg::INDEX_SPAN;
	localparam int USED_WORDS = (LIMIT + WORD_BITS - 1) / WORD_BITS;
	localparam int AW         = (USED_WORDS > 1) ? $clog2(USED_WORDS) : 1;
	localparam int WCNT_W     = $clog2(USED_WORDS + 1);
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int CNT_W      = bba_pkg::CNT_W;
	localparam int IDX_W      = bba_pkg::IDX_W;

	localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LIMIT);
	localparam logic [CNT_W-1:0] WB_C    = CNT_W'(WORD_BITS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOC,
		S_RD,
		S_MOD,
		S_FILL,
		S_SCAN,
		S_FIN
	} state_t;

	state_t                 state_q;
	bba_pkg::req_code_t     req_q;
	logic [IDX_W-1:0]       idx_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       base_q;
	logic [WCNT_W-1:0]      word_q;
	logic                   fill_ones_q;
	logic [CNT_W-1:0]       bit_count_q;

	logic                   res_set_q;
	logic [IDX_W-1:0]       res_alloc_q;
	logic                   res_fail_q;

	logic                   rsp_valid_q;
	logic                   rsp_set_q;
	logic [IDX_W-1:0]       rsp_alloc_q;
	logic                   rsp_fail_q;

	// Scan pipeline: the word read in the previous cycle is checked in this one.
	logic                   chk_vld_s1;
	logic [CNT_W-1:0]       chk_base_s1;
	logic [AW-1:0]          chk_word_s1;

	logic [CNT_W-1:0]       live_count;
	logic [CNT_W-1:0]       base_sum;
	logic                   issue_ok;
	logic [CNT_W-1:0]       left_bits;
	logic [WORD_BITS-1:0]   lim_mask;
	logic [WORD_BITS-1:0]   free_bits;
	logic                   hit;
	logic [BIT_W-1:0]       hit_pos;
	logic                   hit_found;
	logic [CNT_W-1:0]       alloc_sum;
	logic [CNT_W-1:0]       idx_off;
	logic [BIT_W-1:0]       bit_pos;
	logic [WORD_BITS-1:0]   bit_mask;
	logic                   slot_free;

	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [WORD_BITS-1:0]   wr_data;
	logic [WORD_BITS-1:0]   rd_data;

	// ---------------------------------------------------------------- configuration
	assign pready = 1'b1;
	assign prdata = (paddr == bba_pkg::ADDR_BIT_COUNT) ? bba_pkg::APB_DW'(bit_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q <= bba_pkg::BIT_COUNT_RESET;
		end else if (psel && penable && pwrite && (paddr == bba_pkg::ADDR_BIT_COUNT)) begin
			bit_count_q <= pwdata[CNT_W-1:0];
		end
	end

	// The count in use saturates at the store size and the index span.
	assign live_count = (bit_count_q > LIMIT_C) ? LIMIT_C : bit_count_q;

	// ---------------------------------------------------------------- shared datapath
	// One adder steps the word base, for locating a bit, filling and scanning alike.
	assign base_sum = base_q + WB_C;
	assign issue_ok = base_q < count_q;

	// Position of the single-bit target inside its word once the walk has stopped.
	assign idx_off  = {1'b0, idx_q} - base_q;
	assign bit_pos  = idx_off[BIT_W-1:0];
	assign bit_mask = WORD_BITS'(1) << bit_pos;

	// Free bits of the word under check, cut off at the count.
	assign left_bits = count_q - chk_base_s1;

	always_comb begin
		for (int p = 0; p < WORD_BITS; p++) begin
			lim_mask[p] = CNT_W'(p) < left_bits;
		end
	end

	assign free_bits = ~rd_data & lim_mask;

	always_comb begin
		hit     = 1'b0;
		hit_pos = '0;
		for (int p = WORD_BITS - 1; p >= 0; p--) begin
			if (free_bits[p]) begin
				hit     = 1'b1;
				hit_pos = BIT_W'(p);
			end
		end
	end

	assign hit_found = (state_q == S_SCAN) && chk_vld_s1 && hit;
	assign alloc_sum = chk_base_s1 + CNT_W'(hit_pos);

	// ---------------------------------------------------------------- store port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = word_q[AW-1:0];
		wr_data = rd_data;
		unique case (state_q)
			S_MOD: begin
				if (req_q == bba_pkg::REQ_SET) begin
					wr_en   = 1'b1;
					wr_data = rd_data | bit_mask;
				end else if (req_q == bba_pkg::REQ_CLEAR) begin
					wr_en   = 1'b1;
					wr_data = rd_data & ~bit_mask;
				end
			end
			S_FILL: begin
				wr_en   = issue_ok;
				wr_data = fill_ones_q ? '1 : '0;
			end
			S_SCAN: begin
				wr_en   = hit_found;
				wr_addr = chk_word_s1;
				wr_data = rd_data | (WORD_BITS'(1) << hit_pos);
			end
			S_IDLE, S_LOC, S_RD, S_FIN: begin
			end
		endcase
	end

	bba_mark_store #(
		.WORD_BITS (WORD_BITS),
		.DEPTH     (USED_WORDS),
		.AW        (AW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (word_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// ---------------------------------------------------------------- sequencer
	assign req.ready = (state_q == S_IDLE);
	assign slot_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= bba_pkg::REQ_SET;
			idx_q       <= '0;
			count_q     <= '0;
			base_q      <= '0;
			word_q      <= '0;
			fill_ones_q <= 1'b0;
			res_set_q   <= 1'b0;
			res_alloc_q <= '0;
			res_fail_q  <= 1'b0;
			chk_vld_s1  <= 1'b0;
			chk_base_s1 <= '0;
			chk_word_s1 <= '0;
			rsp_valid_q <= 1'b0;
			rsp_set_q   <= 1'b0;
			rsp_alloc_q <= '0;
			rsp_fail_q  <= 1'b0;
		end else begin
			chk_vld_s1  <= (state_q == S_SCAN) && issue_ok && !hit_found;
			chk_base_s1 <= base_q;
			chk_word_s1 <= word_q[AW-1:0];

			// The final state loads the next response itself, so it is left out here.
			if (rsp.ready && (state_q != S_FIN)) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						idx_q       <= req.bit_index;
						count_q     <= live_count;
						base_q      <= '0;
						word_q      <= '0;
						res_set_q   <= 1'b0;
						res_alloc_q <= '0;
						res_fail_q  <= 1'b0;
						unique case (req.req_type)
							bba_pkg::REQ_SET, bba_pkg::REQ_CLEAR, bba_pkg::REQ_TEST: begin
								req_q <= bba_pkg::req_code_t'(req.req_type);
								if ({1'b0, req.bit_index} >= live_count) begin
									res_fail_q <= 1'b1;
									state_q    <= S_FIN;
								end else begin
									state_q <= S_LOC;
								end
							end
							bba_pkg::REQ_SET_ALL, bba_pkg::REQ_CLEAR_ALL: begin
								req_q       <= bba_pkg::req_code_t'(req.req_type);
								fill_ones_q <= (req.req_type == bba_pkg::REQ_SET_ALL);
								state_q     <= S_FILL;
							end
							bba_pkg::REQ_FIND: begin
								req_q   <= bba_pkg::REQ_FIND;
								state_q <= S_SCAN;
							end
							default: begin
								res_fail_q <= 1'b1;
								state_q    <= S_FIN;
							end
						endcase
					end
				end
				S_LOC: begin
					// Step one word forward while the bit lies beyond the current word.
					if ({1'b0, idx_q} >= base_sum) begin
						base_q <= base_sum;
						word_q <= word_q + WCNT_W'(1);
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_MOD;
				end
				S_MOD: begin
					if (req_q == bba_pkg::REQ_TEST) begin
						res_set_q <= rd_data[bit_pos];
					end
					state_q <= S_FIN;
				end
				S_FILL: begin
					if (issue_ok) begin
						base_q <= base_sum;
						word_q <= word_q + WCNT_W'(1);
					end else begin
						state_q <= S_FIN;
					end
				end
				S_SCAN: begin
					if (hit_found) begin
						res_alloc_q <= alloc_sum[IDX_W-1:0];
						state_q     <= S_FIN;
					end else if (issue_ok) begin
						base_q <= base_sum;
						word_q <= word_q + WCNT_W'(1);
					end else if (!chk_vld_s1) begin
						res_fail_q <= 1'b1;
						state_q    <= S_FIN;
					end
				end
				S_FIN: begin
					if (slot_free) begin
						rsp_valid_q <= 1'b1;
						rsp_set_q   <= res_set_q;
						rsp_alloc_q <= res_alloc_q;
						rsp_fail_q  <= res_fail_q;
						state_q     <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.bit_was_set = rsp_set_q;
	assign rsp.alloc_index = rsp_alloc_q;
	assign rsp.failed      = rsp_fail_q;

	// ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
	// A response only appears out of the final state of the sequencer.
	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == S_FIN))
		else $error("response raised outside the final state");

	// A bit handed out always lies below the count in use.
	a_alloc_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		hit_found |-> (alloc_sum < count_q))
		else $error("allocated index not below the count");

	// A set test bit never comes with a failure.
	a_test_not_failed: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_set_q) |-> !rsp_fail_q)
		else $error("test result and failure raised together");

	// The check stage only carries a word read during a scan.
	a_chk_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chk_vld_s1 |-> ($past(state_q) == S_SCAN) && (state_q == S_SCAN))
		else $error("scan check stage valid outside a scan");
`endif

endmodule

@@ tb/tb_bitmap_bit_allocator.sv @@
// Self-checking testbench for the bitmap bit allocator: directed and random requests.
`timescale 1ns / 1ps
module tb_bitmap_bit_allocator;
	import bba_pkg::*;

	// Geometry of the mark store at the block's default parameters.
	localparam int MAP_WORD_BITS = WORD_BITS_DEF;
	localparam int MAP_WORDS     = (TOTAL_BITS_DEF + WORD_BITS_DEF - 1) / WORD_BITS_DEF;

	// Request codes that the block does not define; both must answer with a failure.
	localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd6;
	localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

	// Cycles with no item accepted on either channel before the run is declared hung.
	// The limit lies well above the slowest request, the longest random gap and the
	// deliberate response hold-off, so it leaves a wide margin.
	localparam int STALL_LIMIT  = 4000;
	// Quiet cycles after the last response.
	localparam int DRAIN_CYCLES = 80;
	localparam int PHASE_ITEMS  = 80;

	typedef struct packed {
		logic [REQ_W-1:0] kind;
		logic [IDX_W-1:0] index;
	} request_t;

	typedef struct packed {
		logic             was_set;
		logic [IDX_W-1:0] alloc;
		logic             failed;
	} response_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	bba_req_if req_ch ();
	bba_rsp_if rsp_ch ();

	bitmap_bit_allocator dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Our own copy of the allocation marks and of the bit_count register.
	logic [MAP_WORD_BITS-1:0] mark_map [MAP_WORDS];
	logic [CNT_W-1:0]         model_count;

	// Requests waiting to be offered, and responses predicted for accepted requests.
	request_t  queued_requests [$];
	response_t due_responses   [$];

	int mismatch_count = 0;
	int quiet_cycles   = 0;
	int send_gap       = 0;
	int ready_gap      = 0;
	int sink_hold      = 0;
	// Written by the stimulus at a falling edge; the response side picks it up and
	// counts the hold-off down itself.
	int sink_stall_req = 0;
	// While set, neither side idles.
	bit calm           = 1'b0;

	// Random idle length: mostly none or short, now and then a long one.
	function automatic int idle_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	// Applies one request to the model's marks and returns the response it must produce.
	// The count in use saturates at the store size and at the span of alloc_index.
	function automatic response_t bitmap_apply(request_t r);
		response_t                o;
		int                       live;
		int                       wi;
		int                       bi;
		int                       words;
		int                       left;
		logic [MAP_WORD_BITS-1:0] free_bits;
		logic [31:0]              slot;
		bit                       hit;
		o     = '0;
		hit   = 1'b0;
		live  = int'(model_count);
		if (live > TOTAL_BITS_DEF)
			live = TOTAL_BITS_DEF;
		if (live > INDEX_SPAN)
			live = INDEX_SPAN;
		wi    = int'(r.index) / MAP_WORD_BITS;
		bi    = int'(r.index) % MAP_WORD_BITS;
		words = (live + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
		case (r.kind)
			REQ_SET, REQ_CLEAR, REQ_TEST: begin
				// An index at or above the count fails and leaves the marks alone.
				if (int'(r.index) >= live || wi >= MAP_WORDS)
					o.failed = 1'b1;
				else if (r.kind == REQ_SET)
					mark_map[wi][bi] = 1'b1;
				else if (r.kind == REQ_CLEAR)
					mark_map[wi][bi] = 1'b0;
				else
					o.was_set = mark_map[wi][bi];
			end
			// Whole words are written, including bits above the count in the last one.
			REQ_SET_ALL: begin
				for (int k = 0; k < words && k < MAP_WORDS; k++)
					mark_map[k] = '1;
			end
			REQ_CLEAR_ALL: begin
				for (int k = 0; k < words && k < MAP_WORDS; k++)
					mark_map[k] = '0;
			end
			REQ_FIND: begin
				for (int k = 0; k < words && k < MAP_WORDS && !hit; k++) begin
					free_bits = ~mark_map[k];
					left      = live - k * MAP_WORD_BITS;
					// A clear bit above the count is never handed out.
					if (left < MAP_WORD_BITS)
						free_bits &= {MAP_WORD_BITS{1'b1}} >> (MAP_WORD_BITS - left);
					for (int p = 0; p < MAP_WORD_BITS && !hit; p++) begin
						if (free_bits[p]) begin
							mark_map[k][p] = 1'b1;
							slot           = k * MAP_WORD_BITS + p;
							o.alloc        = slot[IDX_W-1:0];
							hit            = 1'b1;
						end
					end
				end
				if (!hit)
					o.failed = 1'b1;
			end
			default: begin
				o.failed = 1'b1;
			end
		endcase
		return o;
	endfunction

	// Request side. An offered item is held until it is taken; after each accepted item
	// the next one may be delayed by a random gap. The prediction is made at acceptance,
	// so it always sees the marks in the order the block handles the requests.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				due_responses.push_back(bitmap_apply(queued_requests.pop_front()));
				send_gap = idle_gap();
			end
			if (!(req_ch.valid && !req_ch.ready)) begin
				if (send_gap > 0) begin
					send_gap--;
					req_ch.valid <= 1'b0;
				end else if (queued_requests.size() > 0) begin
					req_ch.valid     <= 1'b1;
					req_ch.req_type  <= queued_requests[0].kind;
					req_ch.bit_index <= queued_requests[0].index;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Response side. Each accepted item is checked against the oldest prediction, field
	// by field. Ready drops for random gaps and, once, for a long hold-off that fills
	// the block and stalls its request channel.
	always @(posedge clk) begin : response_check
		response_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (due_responses.size() == 0) begin
					$error("response item arrived with no request outstanding");
					mismatch_count++;
				end else begin
					want = due_responses.pop_front();
					if (rsp_ch.bit_was_set !== want.was_set) begin
						$error("bit_was_set mismatch: expected %0d, actual %0d",
							want.was_set, rsp_ch.bit_was_set);
						mismatch_count++;
					end
					if (rsp_ch.alloc_index !== want.alloc) begin
						$error("alloc_index mismatch: expected %0d, actual %0d",
							want.alloc, rsp_ch.alloc_index);
						mismatch_count++;
					end
					if (rsp_ch.failed !== want.failed) begin
						$error("failed mismatch: expected %0d, actual %0d",
							want.failed, rsp_ch.failed);
						mismatch_count++;
					end
				end
				ready_gap = idle_gap();
			end
			if (sink_stall_req > 0) begin
				sink_hold      = sink_stall_req;
				sink_stall_req = 0;
			end
			if (sink_hold > 0) begin
				sink_hold--;
				rsp_ch.ready <= 1'b0;
			end else if (ready_gap > 0) begin
				ready_gap--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: the run is hung if no item moves on either channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Writes bit_count through a setup and an access cycle. The unused upper data bits
	// carry random values, which the register must ignore. Only called while idle.
	task automatic write_bit_count(input logic [CNT_W-1:0] value);
		logic [APB_DW-1:0] word;
		word             = $urandom();
		word[CNT_W-1:0]  = value;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_BIT_COUNT;
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		model_count  = value;
		@(negedge clk);
	endtask

	task automatic enqueue(input logic [REQ_W-1:0] kind, input logic [IDX_W-1:0] index);
		request_t r;
		r.kind  = kind;
		r.index = index;
		queued_requests.push_back(r);
	endtask

	// One random request. Indexes mostly fall below the count, some sit right at its
	// boundary and the rest are anywhere in the field.
	task automatic enqueue_random(input int live);
		int               roll;
		int               near;
		logic [REQ_W-1:0] kind;
		logic [IDX_W-1:0] index;
		roll = $urandom_range(0, 99);
		if (roll < 30)
			kind = REQ_FIND;
		else if (roll < 50)
			kind = REQ_SET;
		else if (roll < 68)
			kind = REQ_CLEAR;
		else if (roll < 86)
			kind = REQ_TEST;
		else if (roll < 91)
			kind = REQ_SET_ALL;
		else if (roll < 96)
			kind = REQ_CLEAR_ALL;
		else
			kind = $urandom_range(0, 1) ? REQ_UNUSED_LO : REQ_UNUSED_HI;
		roll = $urandom_range(0, 99);
		if (live > 0 && roll < 70) begin
			index = IDX_W'($urandom_range(0, live - 1));
		end else if (roll < 80) begin
			near = $urandom_range(0, 1) ? live - 1 : live;
			if (near < 0)
				near = 0;
			if (near > INDEX_SPAN - 1)
				near = INDEX_SPAN - 1;
			index = near[IDX_W-1:0];
		end else begin
			index = IDX_W'($urandom());
		end
		enqueue(kind, index);
	endtask

	// Blocks until every queued request has been taken and every response checked.
	task automatic wait_drained();
		while (queued_requests.size() != 0 || due_responses.size() != 0)
			@(negedge clk);
	endtask

	// A random phase at one count. With split set, the sender pauses halfway until all
	// responses are in; a nonzero stall holds the response side off while items queue.
	task automatic run_phase(input logic [CNT_W-1:0] count, input int items,
		input bit split, input int stall);
		int live;
		write_bit_count(count);
		live = (int'(count) > INDEX_SPAN) ? INDEX_SPAN : int'(count);
		for (int i = 0; i < items; i++) begin
			if (split && i == items / 2)
				wait_drained();
			enqueue_random(live);
		end
		if (stall > 0) begin
			repeat (12) @(negedge clk);
			sink_stall_req = stall;
		end
		wait_drained();
	endtask

	logic [CNT_W-1:0] phase_counts [12];

	initial begin
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		req_ch.valid     = 1'b0;
		req_ch.req_type  = '0;
		req_ch.bit_index = '0;
		rsp_ch.ready     = 1'b0;
		for (int k = 0; k < MAP_WORDS; k++)
			mark_map[k] = '0;
		model_count = BIT_COUNT_RESET;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset count: the store must start empty, both ends of the
		// index range work, find takes the lowest clear bit and fails on a full map,
		// and the two undefined request codes fail.
		enqueue(REQ_TEST, 10'd0);
		enqueue(REQ_TEST, 10'd1023);
		enqueue(REQ_SET, 10'd0);
		enqueue(REQ_SET, 10'd1023);
		enqueue(REQ_TEST, 10'd1023);
		enqueue(REQ_FIND, 10'd0);
		enqueue(REQ_CLEAR, 10'd0);
		enqueue(REQ_FIND, 10'h3FF);
		enqueue(REQ_SET_ALL, 10'h2AA);
		enqueue(REQ_FIND, 10'd0);
		enqueue(REQ_CLEAR, 10'h155);
		enqueue(REQ_FIND, 10'd0);
		enqueue(REQ_CLEAR_ALL, 10'h155);
		enqueue(REQ_TEST, 10'h2AA);
		enqueue(REQ_UNUSED_LO, 10'd5);
		enqueue(REQ_UNUSED_HI, 10'd5);
		wait_drained();

		// A count that ends inside a word: set all fills both covering words whole and
		// indexes at or above the count fail.
		write_bit_count(11'd40);
		enqueue(REQ_SET_ALL, 10'd0);
		enqueue(REQ_SET, 10'd40);
		enqueue(REQ_TEST, 10'd1023);
		wait_drained();

		// Open a clear bit above 40 in the second word, then drop back to 40: find must
		// not hand that bit out, since it lies above the count.
		write_bit_count(11'd64);
		enqueue(REQ_CLEAR, 10'd50);
		enqueue(REQ_TEST, 10'd50);
		wait_drained();
		write_bit_count(11'd40);
		enqueue(REQ_FIND, 10'd0);
		wait_drained();

		// A count of zero: every single-bit request and find fail, set all and clear all
		// touch no word.
		write_bit_count(11'd0);
		enqueue(REQ_FIND, 10'd0);
		enqueue(REQ_SET, 10'd0);
		enqueue(REQ_SET_ALL, 10'd0);
		enqueue(REQ_CLEAR_ALL, 10'd0);
		wait_drained();

		// Random phases over counts at and around word boundaries and both extremes,
		// including values above the index span, which must saturate.
		phase_counts = '{11'd1024, 11'd2047, 11'd1, 11'd33, 11'd32, 11'd0,
			11'd31, 11'd1000, 11'd1023, 11'd0, 11'd1025, 11'd64};
		phase_counts[9] = CNT_W'($urandom_range(0, 2047));
		foreach (phase_counts[i]) begin
			calm = (i == 4);
			run_phase(phase_counts[i], PHASE_ITEMS, i == 7, (i == 0) ? 400 : 0);
		end
		calm = 1'b0;

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
